### hw/rtl/sobel_pkg.sv
// Shared constants for the Sobel edge filter with line buffers.
`timescale 1ns / 1ps
`default_nettype none

package sobel_pkg;

    localparam int PIX_W = 8;
    localparam int DIM_W = 12;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_COLS = 2048;
    localparam int DEF_MAX_ROWS = 2048;

    localparam int RESET_ROWS = 480;
    localparam int RESET_COLS = 640;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b1;

    // Gradient weight width: |gx| + |gy| never exceeds 2040.
    localparam int GRAD_W = 11;
    localparam logic [GRAD_W-1:0] WEIGHT_LOW = 11'd55;
    localparam logic [GRAD_W-1:0] WEIGHT_HIGH = 11'd205;
    localparam logic [GRAD_W-1:0] PIX_FULL = 11'd255;

endpackage

`default_nettype wire

### hw/rtl/sobel_lbuf.sv
// Two line stores for the Sobel window, with a clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module sobel_lbuf #(
    parameter int MAX_COLS = sobel_pkg::DEF_MAX_COLS
) (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_rd_en,
    input  wire  [$clog2(MAX_COLS)-1:0]            i_rd_addr,
    output logic [sobel_pkg::PIX_W-1:0]            o_rd_old,
    output logic [sobel_pkg::PIX_W-1:0]            o_rd_mid,
    input  wire                                    i_wr_en,
    input  wire  [$clog2(MAX_COLS)-1:0]            i_wr_addr,
    input  wire  [sobel_pkg::PIX_W-1:0]            i_wr_old,
    input  wire  [sobel_pkg::PIX_W-1:0]            i_wr_mid,
    output logic                                   o_busy
);

    localparam int AW = $clog2(MAX_COLS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_COLS - 1);

    logic [sobel_pkg::PIX_W-1:0] r_mem_old [MAX_COLS];
    logic [sobel_pkg::PIX_W-1:0] r_mem_mid [MAX_COLS];

    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic                        wr_en;
    logic [AW-1:0]               wr_addr;
    logic [sobel_pkg::PIX_W-1:0] wr_old;
    logic [sobel_pkg::PIX_W-1:0] wr_mid;

    // The clearing pass owns the write port until every column is zero.
    always_comb begin
        if (r_clr_busy) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_old  = '0;
            wr_mid  = '0;
        end else begin
            wr_en   = i_wr_en;
            wr_addr = i_wr_addr;
            wr_old  = i_wr_old;
            wr_mid  = i_wr_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem_old[wr_addr] <= wr_old;
            r_mem_mid[wr_addr] <= wr_mid;
        end
        if (i_rd_en) begin
            o_rd_old <= r_mem_old[i_rd_addr];
            o_rd_mid <= r_mem_mid[i_rd_addr];
        end
    end

    assign o_busy = r_clr_busy;

endmodule

`default_nettype wire

### hw/rtl/sobel_edge_line_buffer_filter.sv
// Top level of the Sobel 3x3 edge filter with L1 gradient magnitude.
//
//  channel     | direction | fields (low bit first)
//  ------------+-----------+-------------------------------------------
//  s_axis      | in        | tdata[7:0] pixel
//  m_axis      | out       | tdata[7:0] edge_value, tlast frame_end
//  i_cfg_*     | in        | index 0 frame_rows, index 1 frame_cols
//
// One scan step is accepted every clock unless the line stores are clearing
// or the output stalls; its result passes a line store read, then window and
// gradient into the output register. After reset the line stores are cleared
// one column per cycle with s_axis_tready low; configuration writes are taken
// meanwhile. A stalled output register holds the middle stage, which holds the input.
`timescale 1ns / 1ps
`default_nettype none

module sobel_edge_line_buffer_filter #(
    parameter int MAX_COLS = sobel_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = sobel_pkg::DEF_MAX_ROWS
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  wire                                s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire  [7:0]                         s_axis_tdata,   // [7:0] pixel
    output logic                               m_axis_tvalid,
    input  wire                                m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // [7:0] edge_value
    output logic                               m_axis_tlast,   // frame_end
    input  wire                                i_cfg_we,
    input  wire  [sobel_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [sobel_pkg::DIM_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(MAX_COLS);
    localparam int DW = sobel_pkg::DIM_W;
    localparam int PW = sobel_pkg::PIX_W;
    localparam int GW = sobel_pkg::GRAD_W;
    localparam int ROWS_RST_I = (sobel_pkg::RESET_ROWS > MAX_ROWS) ? MAX_ROWS
                                                                    : sobel_pkg::RESET_ROWS;
    localparam int COLS_RST_I = (sobel_pkg::RESET_COLS > MAX_COLS) ? MAX_COLS
                                                                    : sobel_pkg::RESET_COLS;
    localparam logic [DW-1:0] ROWS_RST = DW'(ROWS_RST_I);
    localparam logic [DW-1:0] COLS_RST = DW'(COLS_RST_I);

    // Effective frame size, clamped to 1..MAX when written.
    logic [DW-1:0] r_rows;
    logic [DW-1:0] r_cols;
    logic [DW-1:0] cfg_clamped_rows;
    logic [DW-1:0] cfg_clamped_cols;

    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_clamped_rows = DW'(1);
        end else if ({1'b0, i_cfg_data} > (DW+1)'(MAX_ROWS)) begin
            cfg_clamped_rows = DW'(MAX_ROWS);
        end else begin
            cfg_clamped_rows = i_cfg_data;
        end
        if (i_cfg_data == '0) begin
            cfg_clamped_cols = DW'(1);
        end else if ({1'b0, i_cfg_data} > (DW+1)'(MAX_COLS)) begin
            cfg_clamped_cols = DW'(MAX_COLS);
        end else begin
            cfg_clamped_cols = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= ROWS_RST;
            r_cols <= COLS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                sobel_pkg::REG_FRAME_ROWS: r_rows <= cfg_clamped_rows;
                sobel_pkg::REG_FRAME_COLS: r_cols <= cfg_clamped_cols;
                default: ;
            endcase
        end
    end

    // Scan position and per-step flags.
    logic [DW-1:0] r_row;
    logic [DW-1:0] r_col;
    logic [DW-1:0] cur_row;
    logic [DW-1:0] cur_col;
    logic          row_pad;
    logic          col_pad;
    logic          in_fire;
    logic          lb_busy;

    // Middle stage: transfer accepted, line store data arriving.
    logic          r_b_valid;
    logic          r_b_inside;
    logic          r_b_emit;
    logic          r_b_border;
    logic          r_b_last;
    logic [PW-1:0] r_b_px;
    logic [AW-1:0] r_b_addr;
    logic [PW-1:0] rd_old;
    logic [PW-1:0] rd_mid;
    logic          b_fire;

    // Output register.
    logic          r_o_valid;
    logic [PW-1:0] r_o_edge;
    logic          r_o_last;

    assign cur_row = (r_row > r_rows) ? r_rows : r_row;
    assign cur_col = (r_col > r_cols) ? r_cols : r_col;
    assign row_pad = (cur_row >= r_rows);
    assign col_pad = (cur_col >= r_cols);

    assign b_fire        = r_b_valid && (!r_o_valid || m_axis_tready);
    assign s_axis_tready = !lb_busy && (!r_b_valid || b_fire);
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (in_fire) begin
            if (col_pad) begin
                r_col <= '0;
                r_row <= row_pad ? '0 : cur_row + 1'b1;
            end else begin
                r_col <= cur_col + 1'b1;
                r_row <= cur_row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_fire) begin
            r_b_valid <= 1'b1;
        end else if (b_fire) begin
            r_b_valid <= 1'b0;
        end
    end

    // Output row r-1 / column c-1 is on the border when r or c is 1 or at padding.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b_inside <= !row_pad && !col_pad;
            r_b_emit   <= (cur_row != '0) && (cur_col != '0);
            r_b_border <= (cur_row == DW'(1)) || (cur_col == DW'(1)) || row_pad || col_pad;
            r_b_last   <= row_pad && col_pad;
            r_b_px     <= s_axis_tdata;
            r_b_addr   <= cur_col[AW-1:0];
        end
    end

    sobel_lbuf #(
        .MAX_COLS (MAX_COLS)
    ) u_lbuf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_fire && !row_pad && !col_pad),
        .i_rd_addr (cur_col[AW-1:0]),
        .o_rd_old  (rd_old),
        .o_rd_mid  (rd_mid),
        .i_wr_en   (b_fire && r_b_inside),
        .i_wr_addr (r_b_addr),
        .i_wr_old  (rd_mid),
        .i_wr_mid  (r_b_px),
        .o_busy    (lb_busy)
    );

    // Window: columns a (oldest kept) and b, top to bottom; n is the new column.
    logic [PW-1:0] r_win_a [3];
    logic [PW-1:0] r_win_b [3];
    logic [PW-1:0] new_col [3];

    always_comb begin
        if (r_b_inside) begin
            new_col[0] = rd_old;
            new_col[1] = rd_mid;
            new_col[2] = r_b_px;
        end else begin
            new_col[0] = '0;
            new_col[1] = '0;
            new_col[2] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_win_a[k] <= '0;
                r_win_b[k] <= '0;
            end
        end else if (b_fire) begin
            for (int k = 0; k < 3; k++) begin
                r_win_a[k] <= r_win_b[k];
                r_win_b[k] <= new_col[k];
            end
        end
    end

    // The window of this step has r_win_a as its left column, r_win_b as its
    // middle column and new_col as its right column.
    logic signed [GW-1:0] gx;
    logic signed [GW-1:0] gy;
    logic [GW-1:0]        abs_gx;
    logic [GW-1:0]        abs_gy;
    logic [GW-1:0]        weight;
    logic [PW-1:0]        edge_pix;

    function automatic logic signed [GW-1:0] ext(input logic [PW-1:0] v);
        return $signed({{(GW-PW){1'b0}}, v});
    endfunction

    always_comb begin
        gx = (ext(new_col[0]) - ext(r_win_a[0]))
           + ((ext(new_col[1]) - ext(r_win_a[1])) <<< 1)
           + (ext(new_col[2]) - ext(r_win_a[2]));
        gy = (ext(r_win_a[2]) - ext(r_win_a[0]))
           + ((ext(r_win_b[2]) - ext(r_win_b[0])) <<< 1)
           + (ext(new_col[2]) - ext(new_col[0]));
        abs_gx = gx[GW-1] ? GW'(-gx) : GW'(gx);
        abs_gy = gy[GW-1] ? GW'(-gy) : GW'(gy);
        weight = abs_gx + abs_gy;
        if (r_b_border || weight < sobel_pkg::WEIGHT_LOW) begin
            edge_pix = '0;
        end else if (weight > sobel_pkg::WEIGHT_HIGH) begin
            edge_pix = PW'(sobel_pkg::PIX_FULL);
        end else begin
            edge_pix = PW'(sobel_pkg::PIX_FULL - weight);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (b_fire && r_b_emit) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_fire && r_b_emit) begin
            r_o_edge <= edge_pix;
            r_o_last <= r_b_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_edge;
    assign m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire

### sim/sobel_edge_checker.sv
// Output checker for the Sobel edge filter: predicts each edge pixel and compares transfers.
`timescale 1ns / 1ps

module sobel_edge_checker #(
    parameter int MAX_COLS = sobel_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = sobel_pkg::DEF_MAX_ROWS
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             s_axis_tvalid,
    input  wire                             s_axis_tready,
    input  wire  [7:0]                      s_axis_tdata,   // [7:0] pixel
    input  wire                             m_axis_tvalid,
    input  wire                             m_axis_tready,
    input  wire  [7:0]                      m_axis_tdata,   // [7:0] edge_value
    input  wire                             m_axis_tlast,   // frame_end
    input  wire                             i_cfg_we,
    input  wire  [sobel_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire  [sobel_pkg::DIM_W-1:0]     i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    typedef struct packed {
        logic [7:0] edge_value;
        logic       frame_end;
    } edge_px_t;

    logic [7:0]  line_mem [0:2*MAX_COLS-1];
    logic [7:0]  win [0:2][0:2];
    int unsigned row_pos;
    int unsigned col_pos;
    int unsigned rows_reg;
    int unsigned cols_reg;
    int          fail_total;
    edge_px_t    pending_edges [$];

    task automatic note_failure(input string msg);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: mismatch: %s", $time, msg);
        end
    endtask

    // Advances the scan by one step and queues the edge pixel it produces, if any.
    task automatic predict_step(input logic [7:0] px);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        int unsigned w;
        int          gx;
        int          gy;
        int          m;
        edge_px_t    res;
        rows = (rows_reg < 1) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
        cols = (cols_reg < 1) ? 1 : ((cols_reg > MAX_COLS) ? MAX_COLS : cols_reg);
        // A position beyond a shrunken frame counts as the padding position.
        r = (row_pos > rows) ? rows : row_pos;
        c = (col_pos > cols) ? cols : col_pos;

        for (int k = 0; k < 3; k++) begin
            win[k][0] = win[k][1];
            win[k][1] = win[k][2];
        end
        if (r < rows && c < cols) begin
            win[0][2] = line_mem[c];
            win[1][2] = line_mem[MAX_COLS + c];
            win[2][2] = px;
            line_mem[c] = line_mem[MAX_COLS + c];
            line_mem[MAX_COLS + c] = px;
        end else begin
            win[0][2] = 8'd0;
            win[1][2] = 8'd0;
            win[2][2] = 8'd0;
        end

        if (r >= 1 && c >= 1) begin
            res.edge_value = 8'd0;
            if (!(r - 1 == 0 || c - 1 == 0 || r - 1 >= rows - 1 || c - 1 >= cols - 1)) begin
                gx = 0;
                gy = 0;
                for (int k = 0; k < 3; k++) begin
                    m = (k == 1) ? 2 : 1;
                    gx += m * (int'(win[k][2]) - int'(win[k][0]));
                    gy += m * (int'(win[2][k]) - int'(win[0][k]));
                end
                w = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
                if (w < int'(sobel_pkg::WEIGHT_LOW)) begin
                    res.edge_value = 8'd0;
                end else if (w > int'(sobel_pkg::WEIGHT_HIGH)) begin
                    res.edge_value = 8'd255;
                end else begin
                    res.edge_value = 8'(int'(sobel_pkg::PIX_FULL) - w);
                end
            end
            res.frame_end = (r >= rows && c >= cols);
            pending_edges.push_back(res);
        end

        if (c >= cols) begin
            col_pos = 0;
            row_pos = (r >= rows) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin
        edge_px_t want;
        if (!i_rst_n) begin
            for (int k = 0; k < 2 * MAX_COLS; k++) begin
                line_mem[k] = 8'd0;
            end
            for (int k = 0; k < 9; k++) begin
                win[k / 3][k % 3] = 8'd0;
            end
            row_pos = 0;
            col_pos = 0;
            rows_reg = sobel_pkg::RESET_ROWS;
            cols_reg = sobel_pkg::RESET_COLS;
            fail_total = 0;
            pending_edges.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == sobel_pkg::REG_FRAME_ROWS) begin
                    rows_reg = i_cfg_data;
                end else if (i_cfg_index == sobel_pkg::REG_FRAME_COLS) begin
                    cols_reg = i_cfg_data;
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_edges.size() == 0) begin
                    note_failure($sformatf("unexpected output edge_value=%0d frame_end=%0b",
                                           m_axis_tdata, m_axis_tlast));
                end else begin
                    want = pending_edges.pop_front();
                    if (m_axis_tdata !== want.edge_value) begin
                        note_failure($sformatf("edge_value expected %0d got %0d",
                                               want.edge_value, m_axis_tdata));
                    end
                    if (m_axis_tlast !== want.frame_end) begin
                        note_failure($sformatf("frame_end expected %0b got %0b",
                                               want.frame_end, m_axis_tlast));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_step(s_axis_tdata);
            end
        end
        o_pending = pending_edges.size();
        o_fail_count = fail_total;
    end

endmodule

### sim/sobel_edge_line_buffer_filter_tb.sv
// Testbench top for the Sobel edge filter: clock, reset, pixel stimulus and verdict.
`timescale 1ns / 1ps

module sobel_edge_line_buffer_filter_tb;

    localparam int ITEM_TARGET  = 1250;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 8;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [7:0]                      s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [7:0]                      m_axis_tdata;
    logic                            m_axis_tlast;
    logic                            i_cfg_we;
    logic [sobel_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [sobel_pkg::DIM_W-1:0]     i_cfg_data;

    int   fail_count;
    int   pending_count;
    logic pixel_taken = 1'b0;
    int   idle_cycles = 0;
    int   pixels_sent = 0;
    int   burst_left = 1;
    bit   valid_up = 1'b0;
    int   stall_left = 0;
    int   stall_mode = 0;

    sobel_edge_line_buffer_filter DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    sobel_edge_checker edge_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // The receiver switches between stall patterns, picking a new one when the current one runs out.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(30, 150);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: m_axis_tready <= ($urandom_range(0, 1) != 0);
            default: m_axis_tready <= ((stall_left & 7) == 0);
        endcase
    end

    // Watchdog: the run ends if no transfer happens on either side for too long.
    always @(posedge i_clk) begin
        pixel_taken <= s_axis_tvalid && s_axis_tready;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL sobel_edge_line_buffer_filter");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Sends one pixel and then, at the end of a burst, holds off for a random gap.
    task automatic send_pixel(input logic [7:0] px);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        valid_up = 1'b1;
        do @(negedge i_clk); while (!pixel_taken);
        pixels_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                valid_up = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    // Waits until every predicted edge pixel has arrived and the pipeline is empty.
    task automatic drain();
        if (valid_up) begin
            s_axis_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
        while (pending_count != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_dims(input int rows, input int cols);
        i_cfg_we <= 1'b1;
        i_cfg_index <= sobel_pkg::REG_FRAME_ROWS;
        i_cfg_data <= sobel_pkg::DIM_W'(rows);
        @(negedge i_clk);
        i_cfg_index <= sobel_pkg::REG_FRAME_COLS;
        i_cfg_data <= sobel_pkg::DIM_W'(cols);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_dim(input int typical);
        case ($urandom_range(0, 11))
            0: return 0;
            1: return 1;
            2: return 4095;
            3: return sobel_pkg::DEF_MAX_COLS;
            default: return $urandom_range(2, typical);
        endcase
    endfunction

    initial begin
        int         rows_sel;
        int         cols_sel;
        int         rows_eff;
        int         cols_eff;
        int         span;
        int         count;
        int         mode;
        int         base;
        int         slope;
        logic [7:0] px;

        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = sobel_pkg::REG_FRAME_ROWS;
        i_cfg_data = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // One 3x4 frame: each image row is 0,0,30,255, so the two interior pixels
        // see a mid-range weight and a saturating one. Padding steps carry 255,
        // which the block must ignore.
        write_dims(3, 4);
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 5; c++) begin
                if (r == 3 || c == 4) begin
                    send_pixel(8'd255);
                end else begin
                    send_pixel((c < 2) ? 8'd0 : ((c == 2) ? 8'd30 : 8'd255));
                end
            end
        end
        drain();

        while (pixels_sent < ITEM_TARGET) begin
            rows_sel = pick_dim(10);
            cols_sel = pick_dim(16);
            rows_eff = (rows_sel < 1) ? 1
                     : ((rows_sel > sobel_pkg::DEF_MAX_ROWS) ? sobel_pkg::DEF_MAX_ROWS
                                                             : rows_sel);
            cols_eff = (cols_sel < 1) ? 1
                     : ((cols_sel > sobel_pkg::DEF_MAX_COLS) ? sobel_pkg::DEF_MAX_COLS
                                                             : cols_sel);
            write_dims(rows_sel, cols_sel);

            // Small frames run whole, sometimes with a partial frame tacked on so
            // the next setting lands mid-frame; large frames are cut short.
            span = (rows_eff + 1) * (cols_eff + 1);
            if (span <= 200) begin
                count = span * $urandom_range(1, 3);
                if ($urandom_range(0, 3) == 0) begin
                    count += $urandom_range(1, span - 1);
                end
            end else begin
                count = $urandom_range(40, 160);
            end
            if (count > ITEM_TARGET - pixels_sent) begin
                count = ITEM_TARGET - pixels_sent;
            end

            // Random, smooth, ramp and impulse content; smooth content keeps weights in the mapped range.
            mode = $urandom_range(0, 3);
            base = $urandom_range(0, 243);
            slope = $urandom_range(0, 24);
            for (int k = 0; k < count; k++) begin
                case (mode)
                    0: px = 8'($urandom);
                    1: px = 8'(base + $urandom_range(0, 12));
                    2: px = 8'(base + slope * k);
                    default: px = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(base);
                endcase
                send_pixel(px);
            end
            drain();
        end

        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS sobel_edge_line_buffer_filter");
        end else begin
            $display("FAIL sobel_edge_line_buffer_filter");
        end
        $finish;
    end

endmodule
